// ----- sv/word_tokenizer_line_tracker_assert.svh -----
// Assertion macros for the word tokenizer.
// Included by the top level; compiled to nothing when SYNTHESIS is defined.
`ifndef WORD_TOKENIZER_LINE_TRACKER_ASSERT_SVH
`define WORD_TOKENIZER_LINE_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define WTL_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define WTL_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define WTL_ASSERT_ALWAYS(label, cond, msg)
`define WTL_ASSERT_IMPLIES(label, ante, cons, msg)
`endif
`endif

// ----- sv/wtl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, character constants and classification functions
// for the word tokenizer. No dependencies.
package wtl_pkg;

	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_HYPHEN  = 8'h2D;
	localparam logic [7:0] CH_APOS    = 8'h27;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	localparam int LINE_W = 32;
	localparam logic [LINE_W-1:0] LINE_FIRST = 32'd1;
	localparam logic [LINE_W-1:0] LINE_LAST  = 32'hFFFF_FFFF;

	// Per-word details that travel with an emit command
	typedef struct packed {
		logic              bank;
		logic              too_long;
		logic [LINE_W-1:0] line;
	} cmd_info_t;

	// One character on its way to the output
	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic              too_long;
		logic              last;
		logic [7:0]        ch;
	} char_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return is_digit(c) || is_upper(c) || ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z))
			|| (c == CH_HYPHEN) || (c == CH_APOS);
	endfunction

endpackage

// ----- sv/word_tokenizer_line_tracker.sv -----
`timescale 1ns / 1ps
// Word tokenizer with line tracking: one text byte per item in, one word character per item out.
// Input: one byte per cycle while a buffer bank is free; else input stalls until the oldest word is read out.
// Output: one character per cycle while the output is ready, set by the single read port of the word buffer memory.
// From a word's ending byte to its first output character: command queue, read state, buffer read, output register.
// Reset (arst_n low, asynchronous): line count to one, no word, no skip, queues empty; buffer not cleared.
module word_tokenizer_line_tracker #(
	parameter int MAX_WORD_LEN = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
	input  logic        s_axis_tuser,  // [0] end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [7:0] word_char, [39:8] line_number
	output logic        m_axis_tuser,  // [0] too_long
	output logic        m_axis_tlast   // last_char
);
	import wtl_pkg::*;

	`include "word_tokenizer_line_tracker_assert.svh"

	localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
	localparam int IDX_W  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int ADDR_W = IDX_W + 1;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              cmd_push;
	logic [LEN_W-1:0]  push_len;
	cmd_info_t         push_info;
	logic              cmd_pop;
	logic              cmd_valid;
	logic              fifo_full;
	logic [LEN_W-1:0]  head_len;
	cmd_info_t         head_info;
	logic              release_bank;
	char_t             out_char;

	wtl_front #(
		.MAX_WORD_LEN(MAX_WORD_LEN),
		.LEN_W       (LEN_W),
		.ADDR_W      (ADDR_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.text_byte   (s_axis_tdata),
		.end_of_text (s_axis_tuser),
		.release_bank(release_bank),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.cmd_push    (cmd_push),
		.cmd_len     (push_len),
		.cmd_info    (push_info)
	);

	wtl_cmd_fifo #(
		.LEN_W(LEN_W)
	) u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_len (push_len),
		.push_info(push_info),
		.pop      (cmd_pop),
		.not_empty(cmd_valid),
		.full     (fifo_full),
		.head_len (head_len),
		.head_info(head_info)
	);

	wtl_back #(
		.LEN_W (LEN_W),
		.ADDR_W(ADDR_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.cmd_valid   (cmd_valid),
		.cmd_len     (head_len),
		.cmd_info    (head_info),
		.cmd_pop     (cmd_pop),
		.release_bank(release_bank),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_char    (out_char)
	);

	assign m_axis_tdata = {out_char.line, out_char.ch};
	assign m_axis_tuser = out_char.too_long;
	assign m_axis_tlast = out_char.last;

	`WTL_ASSERT_IMPLIES(a_push_has_room, cmd_push, !fifo_full, "command pushed into full queue")
	`WTL_ASSERT_IMPLIES(a_pop_has_cmd, cmd_pop, cmd_valid, "command popped from empty queue")
	`WTL_ASSERT_IMPLIES(a_ready_has_room, s_axis_tready, !fifo_full, "input ready with full queue")
	`WTL_ASSERT_IMPLIES(a_queued_len_nonzero, cmd_push, push_len != '0, "empty word queued")

endmodule

// ----- sv/wtl_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts text bytes, classifies them, fills the word buffer banks
// and pushes emit commands. Depends on wtl_pkg.
module wtl_front #(
	parameter int MAX_WORD_LEN = 20,
	parameter int LEN_W = 5,
	parameter int ADDR_W = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          text_byte,
	input  logic                end_of_text,
	input  logic                release_bank,
	output logic                wr_en,
	output logic [ADDR_W-1:0]   wr_addr,
	output logic [7:0]          wr_data,
	output logic                cmd_push,
	output logic [LEN_W-1:0]    cmd_len,
	output wtl_pkg::cmd_info_t  cmd_info
);
	import wtl_pkg::*;

	localparam int IDX_W = ADDR_W - 1;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD_LEN);

	logic [LEN_W-1:0]  len_q, len_d;
	logic              skip_q, skip_d;
	logic [LINE_W-1:0] line_q, line_d;
	logic              bank_q;
	logic [1:0]        busy_q;
	logic              accept;
	logic              too_long;

	// two banks: take bytes while the current one is not held by the back end
	assign in_ready = (busy_q != 2'd2);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd_push = 1'b0;
		too_long = 1'b0;
		wr_en    = 1'b0;
		len_d    = len_q;
		skip_d   = skip_q;
		line_d   = line_q;
		if (accept) begin
			if (end_of_text) begin
				skip_d = 1'b0;
				cmd_push = (len_q != '0);
			end else if (is_word_char(text_byte)) begin
				if (!skip_q) begin
					if (len_q == LEN_MAX) begin
						cmd_push = 1'b1;
						too_long = 1'b1;
						skip_d   = 1'b1;
					end else if (is_digit(text_byte)) begin
						len_d  = '0;
						skip_d = 1'b1;
					end else begin
						wr_en = 1'b1;
						len_d = len_q + 1'b1;
					end
				end
			end else begin
				if (skip_q) begin
					skip_d = 1'b0;
				end else begin
					cmd_push = (len_q != '0);
				end
				if ((text_byte == CH_NEWLINE) && (line_q != LINE_LAST)) begin
					line_d = line_q + 1'b1;
				end
			end
			if (cmd_push) begin
				len_d = '0;
			end
		end
	end

	assign wr_addr = {bank_q, len_q[IDX_W-1:0]};
	assign wr_data = is_upper(text_byte) ? (text_byte + CASE_OFFSET) : text_byte;

	assign cmd_len           = len_q;
	assign cmd_info.bank     = bank_q;
	assign cmd_info.too_long = too_long;
	assign cmd_info.line     = line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			skip_q <= 1'b0;
			line_q <= LINE_FIRST;
			bank_q <= 1'b0;
			busy_q <= 2'd0;
		end else begin
			len_q  <= len_d;
			skip_q <= skip_d;
			line_q <= line_d;
			if (cmd_push) begin
				bank_q <= ~bank_q;
			end
			case ({cmd_push, release_bank})
				2'b10:   busy_q <= busy_q + 2'd1;
				2'b01:   busy_q <= busy_q - 2'd1;
				default: busy_q <= busy_q;
			endcase
		end
	end

endmodule

// ----- sv/wtl_cmd_fifo.sv -----
`timescale 1ns / 1ps
// Two-entry queue of emit commands between front and back end.
// Depends on wtl_pkg.
module wtl_cmd_fifo #(
	parameter int LEN_W = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [LEN_W-1:0]   push_len,
	input  wtl_pkg::cmd_info_t push_info,
	input  logic               pop,
	output logic               not_empty,
	output logic               full,
	output logic [LEN_W-1:0]   head_len,
	output wtl_pkg::cmd_info_t head_info
);
	import wtl_pkg::*;

	logic [LEN_W-1:0] len_q  [2];
	cmd_info_t        info_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;

	assign not_empty = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign head_len  = len_q[rd_ptr_q];
	assign head_info = info_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			len_q[wr_ptr_q]  <= push_len;
			info_q[wr_ptr_q] <= push_info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/wtl_back.sv -----
`timescale 1ns / 1ps
// Back end: holds the two-bank word buffer, reads out queued words one character a cycle
// if there is room and drives the output register with a skid stage. Depends on wtl_pkg.
module wtl_back #(
	parameter int LEN_W = 5,
	parameter int ADDR_W = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [7:0]         wr_data,
	input  logic               cmd_valid,
	input  logic [LEN_W-1:0]   cmd_len,
	input  wtl_pkg::cmd_info_t cmd_info,
	output logic               cmd_pop,
	output logic               release_bank,
	output logic               out_valid,
	input  logic               out_ready,
	output wtl_pkg::char_t     out_char
);
	import wtl_pkg::*;

	localparam int IDX_W = ADDR_W - 1;
	localparam int DEPTH = 1 << ADDR_W;

	logic [7:0]       mem [DEPTH];

	logic             active_q;
	logic             bank_q;
	logic             too_long_q;
	logic [LINE_W-1:0] line_q;
	logic [LEN_W-1:0] len_q;
	logic [IDX_W-1:0] idx_q;

	logic             rd_valid_s1;
	logic [7:0]       rd_data_s1;
	logic             last_s1;
	logic             too_long_s1;
	logic [LINE_W-1:0] line_s1;

	logic             out_valid_q;
	char_t            out_q;
	logic             skid_valid_q;
	char_t            skid_q;

	char_t            arr_s1;
	logic             pop_out;
	logic             out_free;
	logic [1:0]       occ;
	logic             room;
	logic             issue;
	logic             last_rd;

	assign pop_out  = out_valid_q && out_ready;
	assign out_free = !out_valid_q || pop_out;
	assign occ      = 2'(out_valid_q) + 2'(skid_valid_q) + 2'(rd_valid_s1);
	// a read may start only if out and skid can still hold it when it lands
	assign room     = (occ < 2'd2) || ((occ == 2'd2) && pop_out);
	assign issue    = active_q && room;
	assign last_rd  = (LEN_W'(idx_q) + 1'b1) == len_q;

	assign release_bank = issue && last_rd;
	assign cmd_pop      = cmd_valid && (!active_q || release_bank);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem[{bank_q, idx_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			bank_q     <= cmd_info.bank;
			too_long_q <= cmd_info.too_long;
			line_q     <= cmd_info.line;
			len_q      <= cmd_len;
		end
		if (issue) begin
			last_s1     <= last_rd;
			too_long_s1 <= too_long_q;
			line_s1     <= line_q;
		end
	end

	assign arr_s1.line     = line_s1;
	assign arr_s1.too_long = too_long_s1;
	assign arr_s1.last     = last_s1;
	assign arr_s1.ch       = rd_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (cmd_pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (release_bank) begin
				active_q <= 1'b0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// output register with one skid entry
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (rd_valid_s1) begin
					skid_q <= arr_s1;
				end
			end else if (rd_valid_s1) begin
				out_q <= arr_s1;
			end
		end else if (rd_valid_s1) begin
			skid_q <= arr_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q || rd_valid_s1;
				skid_valid_q <= skid_valid_q && rd_valid_s1;
			end else if (rd_valid_s1) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_q;

endmodule
